/* hdl/rvh_pkg.sv */
// Shared types and constants for the ranged value histogram.
// Used by the front end, back end and top level; depends on nothing.
package rvh_pkg;

   typedef enum logic [1:0] {
      KIND_CLEAR  = 2'd0,
      KIND_SAMPLE = 2'd1,
      KIND_READ   = 2'd2,
      KIND_NONE   = 2'd3
   } kind_type;

   localparam logic CSR_RANGE_LOW  = 1'b0;
   localparam logic CSR_RANGE_HIGH = 1'b1;

   localparam int DENSITY_WIDTH = 16;
   localparam int SAMPLE_WIDTH  = 16;
   localparam int INDEX_WIDTH   = 12;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_CLEAR,
      ST_INC_RD,
      ST_INC_WR,
      ST_READ_RD,
      ST_DIVIDE,
      ST_OUTPUT
   } back_state_type;

   // Classified operation handed from front to back end.
   typedef struct packed {
      kind_type          kind;
      logic              hit;
      logic [INDEX_WIDTH+4:0] bin;
   } op_type;

endpackage

/* hdl/rvh_front.sv */
// Front end: accepts transactions, classifies them against the range registers.
// Depends on rvh_pkg; feeds a two-entry queue towards the back end.
module rvh_front #(
   parameter int NUM_BINS = 4096
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  logic [1:0]           req_kind,
   input  logic signed [15:0]   req_sample,
   input  logic [11:0]          req_bin_index,
   input  logic signed [15:0]   range_low,
   input  logic signed [15:0]   range_high,
   output logic                 op_valid,
   input  logic                 op_ready,
   output rvh_pkg::op_type      op_data
);
   localparam int BW = rvh_pkg::INDEX_WIDTH + 5;

   rvh_pkg::op_type q_ff [2];
   rvh_pkg::op_type q_in;
   logic [1:0] cnt_ff, cnt_in;
   logic signed [16:0] diff;
   logic push, pop, to_head;

   always_comb begin
      diff = 17'(req_sample) - 17'(range_low);
      q_in.kind = rvh_pkg::kind_type'(req_kind);
      q_in.hit  = 1'b0;
      q_in.bin  = '0;
      if (req_kind == rvh_pkg::KIND_SAMPLE) begin
         q_in.hit = (req_sample > range_low) && (req_sample < range_high)
                    && (diff < 17'sd0 + $signed({1'b0, 17'(NUM_BINS)}));
         q_in.bin = BW'(diff);
      end else if (req_kind == rvh_pkg::KIND_READ) begin
         q_in.hit = 32'(req_bin_index) < NUM_BINS;
         q_in.bin = BW'(req_bin_index);
      end
   end

   assign req_ready = cnt_ff != 2'd2;
   assign push = req_valid && req_ready;
   assign op_valid = cnt_ff != 2'd0;
   assign pop = op_valid && op_ready;
   assign op_data = q_ff[0];
   assign to_head = push && (cnt_ff == 2'd0 || (cnt_ff == 2'd1 && pop));

   always_comb begin
      cnt_in = cnt_ff + 2'(push) - 2'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
      end else begin
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (to_head) begin
         q_ff[0] <= q_in;
      end else if (pop) begin
         q_ff[0] <= q_ff[1];
      end
      if (push && !to_head) begin
         q_ff[1] <= q_in;
      end
   end

   assert property (@(posedge clock) disable iff (reset) cnt_ff != 2'd3)
      else $error("queue count out of range");
   assert property (@(posedge clock) disable iff (reset)
      (cnt_ff == 2'd2 && !pop) |=> cnt_ff == 2'd2)
      else $error("full queue lost an entry");
   assert property (@(posedge clock) disable iff (reset)
      (cnt_ff == 2'd0 && push) |=> op_valid)
      else $error("pushed entry not visible");
endmodule

/* hdl/rvh_back.sv */
// Back end: bin memory, sample total, clear sweep and density divider.
// Depends on rvh_pkg; takes classified operations from rvh_front.
module rvh_back #(
   parameter int NUM_BINS    = 4096,
   parameter int COUNT_WIDTH = 24
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   op_valid,
   output logic                   op_ready,
   input  rvh_pkg::op_type        op_data,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output logic [23:0]            rsp_bin_count,
   output logic [23:0]            rsp_total_count,
   output logic [15:0]            rsp_density
);
   localparam int AW = $clog2(NUM_BINS);
   localparam int DW = COUNT_WIDTH + rvh_pkg::DENSITY_WIDTH;
   localparam logic [COUNT_WIDTH-1:0] CMAX = '1;
   localparam logic [AW:0] LAST = (AW+1)'(NUM_BINS - 1);

   logic [COUNT_WIDTH-1:0] mem [NUM_BINS];
   logic [COUNT_WIDTH-1:0] rd_ff, tot_ff, tot_in, cnt_ff, cnt_in, wdat;
   logic [AW-1:0] addr_ff, addr_in;
   logic [AW:0] sweep_ff, sweep_in;
   logic hit_ff, hit_in, we;
   logic [AW-1:0] waddr;
   rvh_pkg::back_state_type st_ff, st_in;
   logic [DW-1:0] rem_ff, rem_in;
   logic [rvh_pkg::DENSITY_WIDTH:0] quo_ff, quo_in;
   logic [4:0] step_ff, step_in;
   logic [DW:0] trial;
   logic [15:0] dens_ff, dens_in;
   logic [23:0] ob_ff, ob_in, ot_ff, ot_in;
   logic ov_ff, ov_in;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdat;
      end
      rd_ff <= mem[addr_in];
   end

   always_comb begin
      st_in = st_ff; addr_in = addr_ff; sweep_in = sweep_ff; hit_in = hit_ff;
      tot_in = tot_ff; cnt_in = cnt_ff; rem_in = rem_ff; quo_in = quo_ff;
      step_in = step_ff; dens_in = dens_ff; ob_in = ob_ff; ot_in = ot_ff;
      ov_in = ov_ff && !rsp_ready;
      we = 1'b0; waddr = addr_ff; wdat = '0; op_ready = 1'b0;
      trial = {1'b0, rem_ff} - ({1'b0, DW'(tot_ff)} << step_ff);
      case (st_ff)
         rvh_pkg::ST_IDLE: begin
            op_ready = 1'b1;
            if (op_valid) begin
               addr_in = AW'(op_data.bin);
               hit_in = op_data.hit;
               case (op_data.kind)
                  rvh_pkg::KIND_CLEAR: begin
                     tot_in = '0; sweep_in = '0; st_in = rvh_pkg::ST_CLEAR;
                  end
                  rvh_pkg::KIND_SAMPLE: begin
                     if (tot_ff != CMAX) tot_in = tot_ff + 1'b1;
                     if (op_data.hit) st_in = rvh_pkg::ST_INC_RD;
                  end
                  rvh_pkg::KIND_READ: st_in = rvh_pkg::ST_READ_RD;
                  default: ;
               endcase
            end
         end
         rvh_pkg::ST_CLEAR: begin
            we = 1'b1; waddr = AW'(sweep_ff);
            sweep_in = sweep_ff + 1'b1;
            if (sweep_ff == LAST) st_in = rvh_pkg::ST_IDLE;
         end
         rvh_pkg::ST_INC_RD: st_in = rvh_pkg::ST_INC_WR;
         rvh_pkg::ST_INC_WR: begin
            we = 1'b1;
            wdat = (rd_ff == CMAX) ? rd_ff : rd_ff + 1'b1;
            st_in = rvh_pkg::ST_IDLE;
         end
         rvh_pkg::ST_READ_RD: begin
            cnt_in = hit_ff ? rd_ff : '0;
            rem_in = DW'(hit_ff ? rd_ff : '0) << rvh_pkg::DENSITY_WIDTH;
            quo_in = '0;
            step_in = 5'(rvh_pkg::DENSITY_WIDTH);
            st_in = rvh_pkg::ST_DIVIDE;
         end
         rvh_pkg::ST_DIVIDE: begin
            if (tot_ff != '0 && !trial[DW]) begin
               rem_in = trial[DW-1:0];
               quo_in = quo_ff | (17'(1) << step_ff);
            end
            step_in = step_ff - 1'b1;
            if (step_ff == 5'd0) st_in = rvh_pkg::ST_OUTPUT;
         end
         rvh_pkg::ST_OUTPUT: begin
            if (!ov_ff || rsp_ready) begin
               ov_in = 1'b1;
               ob_in = 24'(cnt_ff);
               ot_in = 24'(tot_ff);
               dens_in = quo_ff[16] ? 16'hFFFF : quo_ff[15:0];
               st_in = rvh_pkg::ST_IDLE;
            end
         end
         default: st_in = rvh_pkg::ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff <= rvh_pkg::ST_CLEAR;
         sweep_ff <= '0;
         tot_ff <= '0;
         ov_ff <= 1'b0;
      end else begin
         st_ff <= st_in;
         sweep_ff <= sweep_in;
         tot_ff <= tot_in;
         ov_ff <= ov_in;
      end
   end

   always_ff @(posedge clock) begin
      addr_ff <= addr_in; hit_ff <= hit_in; cnt_ff <= cnt_in;
      rem_ff <= rem_in; quo_ff <= quo_in; step_ff <= step_in;
      dens_ff <= dens_in; ob_ff <= ob_in; ot_ff <= ot_in;
   end

   assign rsp_valid = ov_ff;
   assign rsp_bin_count = ob_ff;
   assign rsp_total_count = ot_ff;
   assign rsp_density = dens_ff;

   assert property (@(posedge clock) disable iff (reset)
      (st_ff == rvh_pkg::ST_INC_RD) |=> st_ff == rvh_pkg::ST_INC_WR)
      else $error("increment lost its write");
   assert property (@(posedge clock) disable iff (reset)
      (st_ff == rvh_pkg::ST_CLEAR) |-> !op_ready)
      else $error("accepted during clear");
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_total_count == 24'd0) |-> rsp_density == 16'd0)
      else $error("density nonzero with empty total");
endmodule

/* hdl/ranged_value_histogram_top.sv */
// Top level of the ranged value histogram: range registers, front end and back end.
// Depends on rvh_pkg, rvh_front and rvh_back.
// Samples outside the range return straight to idle in the back end; a sample that hits a bin
// reads and then writes the bin memory (separate read and write ports); a read runs through the
// one-bit-a-cycle density divider; a clear sweeps every bin of the store. After reset the same
// sweep runs before the first transaction is executed; up to two transactions are queued
// meanwhile. Registers are written at any edge with csr_write high.
module ranged_value_histogram_top #(
   parameter int NUM_BINS    = 4096,
   parameter int COUNT_WIDTH = 24
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic [1:0]         req_kind,
   input  logic signed [15:0] req_sample,
   input  logic [11:0]        req_bin_index,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic [23:0]        rsp_bin_count,
   output logic [23:0]        rsp_total_count,
   output logic [15:0]        rsp_density,
   input  logic               csr_write,
   input  logic               csr_index,
   input  logic [15:0]        csr_data
);
   logic signed [15:0] low_ff, high_ff;
   logic op_valid, op_ready;
   rvh_pkg::op_type op_data;

   always_ff @(posedge clock) begin
      if (reset) begin
         low_ff <= 16'sd0;
         high_ff <= 16'sd4096;
      end else if (csr_write) begin
         if (csr_index == rvh_pkg::CSR_RANGE_LOW) low_ff <= csr_data;
         else high_ff <= csr_data;
      end
   end

   rvh_front #(.NUM_BINS(NUM_BINS)) u_front (
      .clock, .reset, .req_valid, .req_ready, .req_kind, .req_sample, .req_bin_index,
      .range_low(low_ff), .range_high(high_ff), .op_valid, .op_ready, .op_data
   );

   rvh_back #(.NUM_BINS(NUM_BINS), .COUNT_WIDTH(COUNT_WIDTH)) u_back (
      .clock, .reset, .op_valid, .op_ready, .op_data, .rsp_valid, .rsp_ready,
      .rsp_bin_count, .rsp_total_count, .rsp_density
   );
endmodule
